/* design/assert_macros.svh */
// Assertion helpers for the name decompressor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`endif

/* design/dnd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared constants and types of the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnd_pkg;
   localparam int MESSAGE_DEPTH_DEF = 512;
   localparam int NAME_CAPACITY_DEF = 255;
   localparam int MAX_JUMPS_DEF     = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam logic [7:0] PTR_MASK  = 8'hC0;
   localparam logic [7:0] OFS_MASK  = 8'h3F;

   typedef enum logic {OP_WRITE = 1'b0, OP_DECODE = 1'b1} op_type;

   typedef struct packed {
      logic [8:0] start;
      logic [9:0] len;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HEAD, ST_PTR2, ST_CHECK, ST_COPY, ST_EMIT, ST_FAIL, ST_CLEAR
   } state_type;
endpackage

/* design/dnd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_front
// Accepts request words, passes byte writes on and queues decode commands.
// ----------------------------------------------------------------------------
module dnd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [8:0]       req_offset,
   input  logic [7:0]       req_byte_value,
   input  logic [9:0]       req_message_length,
   output logic             wr_en,
   output logic [8:0]       wr_addr,
   output logic [7:0]       wr_data,
   output logic             cmd_valid,
   output dnd_pkg::cmd_type cmd,
   input  logic             cmd_take
);
   localparam int QD = dnd_pkg::QUEUE_DEPTH;
   dnd_pkg::cmd_type q_ff [QD];
   logic [0:0] rd_ff, rd_in, wp_ff, wp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       acc, push;
   logic [9:0] len_sat;

   // byte writes are held off while a decode is queued, keeping order
   assign req_stall = (cnt_ff == 2'(QD)) ||
                      (req_operation == dnd_pkg::OP_WRITE && cnt_ff != 2'd0);
   assign acc  = req_valid && !req_stall;
   assign push = acc && req_operation == dnd_pkg::OP_DECODE;
   assign wr_en   = acc && req_operation == dnd_pkg::OP_WRITE &&
                    ({1'b0, req_offset} < 10'(dnd_pkg::MESSAGE_DEPTH_DEF));
   assign wr_addr = req_offset;
   assign wr_data = req_byte_value;
   assign len_sat = (req_message_length > 10'(dnd_pkg::MESSAGE_DEPTH_DEF)) ?
                    10'(dnd_pkg::MESSAGE_DEPTH_DEF) : req_message_length;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd = q_ff[rd_ff];

   always_comb begin
      rd_in  = rd_ff + 1'(cmd_take);
      wp_in  = wp_ff + 1'(push);
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wp_ff <= '0; cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in; wp_ff <= wp_in; cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff].start <= req_offset;
         q_ff[wp_ff].len   <= len_sat;
      end
   end
endmodule

/* design/dnd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_back
// Message store and label walker; emits name words or one error word.
// ----------------------------------------------------------------------------
module dnd_back #(
   parameter int NAME_CAPACITY = dnd_pkg::NAME_CAPACITY_DEF,
   parameter int MAX_JUMPS     = dnd_pkg::MAX_JUMPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [8:0]       wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             cmd_valid,
   input  dnd_pkg::cmd_type cmd,
   output logic             cmd_take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [63:0]      rsp_name_word,
   output logic [3:0]       rsp_valid_bytes,
   output logic             rsp_last_word,
   output logic             rsp_status,
   output logic [9:0]       rsp_next_offset
);
   localparam int JW = $clog2(MAX_JUMPS + 1);
   localparam int JI = (MAX_JUMPS > 1) ? $clog2(MAX_JUMPS) : 1;
   localparam int NW = $clog2(NAME_CAPACITY + 1);
   localparam int NI = $clog2(NAME_CAPACITY);

   logic [7:0] mem [dnd_pkg::MESSAGE_DEPTH_DEF];
   logic [7:0] nbuf [NAME_CAPACITY];
   logic [13:0] jt_ff [MAX_JUMPS];

   dnd_pkg::state_type st_ff, st_in;
   logic [9:0]  pos_ff, pos_in, len_ff, aft_ff, aft_in;
   logic        jmp_ff, jmp_in;
   logic [JW-1:0] jn_ff, jn_in, ci_ff, ci_in;
   logic [NW-1:0] nl_ff, nl_in, rp_ff, rp_in;
   logic [7:0]  lab_ff, lab_in, rem_ff, rem_in;
   logic [13:0] tgt_ff, tgt_in;
   logic [7:0]  rdata_ff;
   logic [8:0]  raddr;
   logic        nb_we;
   logic [NI-1:0] nb_wa, nb_ra;
   logic [7:0]  nb_wd, nbrd_ff;
   logic [63:0] wrd_ff, wrd_in;
   logic [3:0]  wc_ff, wc_in;
   logic        ov_ff, ov_in, ol_ff, ol_in, os_ff, os_in;
   logic [3:0]  ob_ff, ob_in;
   logic [63:0] ow_ff, ow_in;
   logic [9:0]  on_ff, on_in;
   logic [NW-1:0] rem_n;
   logic        out_free, jclr;

   assign out_free = !ov_ff || !rsp_stall;
   assign rsp_valid = ov_ff;
   assign rsp_name_word = ow_ff;
   assign rsp_valid_bytes = ob_ff;
   assign rsp_last_word = ol_ff;
   assign rsp_status = os_ff;
   assign rsp_next_offset = on_ff;
   assign raddr = pos_in[8:0];
   assign rem_n = NW'(nl_ff) - NW'(rp_ff);
   // name buffer is addressed from the next-state pointers, so its registered byte meets the gather step
   assign nb_ra = rp_in[NI-1:0] + NI'(wc_in);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[raddr];
      if (nb_we) nbuf[nb_wa] <= nb_wd;
      nbrd_ff <= (nb_we && nb_wa == nb_ra) ? nb_wd : nbuf[nb_ra];
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         dnd_pkg::ST_IDLE:
            if (cmd_valid) st_in = ({1'b0, cmd.start} >= cmd.len) ?
                                   dnd_pkg::ST_FAIL : dnd_pkg::ST_HEAD;
         dnd_pkg::ST_HEAD: begin
            if (pos_ff >= len_ff) st_in = dnd_pkg::ST_FAIL;
            else if ((rdata_ff & dnd_pkg::PTR_MASK) == dnd_pkg::PTR_MASK)
               st_in = (pos_ff + 10'd1 >= len_ff || jn_ff >= JW'(MAX_JUMPS)) ?
                       dnd_pkg::ST_FAIL : dnd_pkg::ST_PTR2;
            else if ((rdata_ff & dnd_pkg::PTR_MASK) != 8'd0) st_in = dnd_pkg::ST_FAIL;
            else if (rdata_ff == 8'd0)
               st_in = (nl_ff >= NW'(NAME_CAPACITY)) ? dnd_pkg::ST_FAIL :
                       dnd_pkg::ST_EMIT;
            else if ({2'b0, rdata_ff} > len_ff - pos_ff - 10'd1 ||
                     11'(nl_ff) + 11'(rdata_ff) + 11'd2 > 11'(NAME_CAPACITY))
               st_in = dnd_pkg::ST_FAIL;
            else st_in = dnd_pkg::ST_COPY;
         end
         dnd_pkg::ST_PTR2:
            st_in = (tgt_in >= 14'(len_ff)) ? dnd_pkg::ST_FAIL : dnd_pkg::ST_CHECK;
         dnd_pkg::ST_CHECK:
            if (ci_ff == jn_ff) st_in = dnd_pkg::ST_HEAD;
            else if (jt_ff[ci_ff[JI-1:0]] == tgt_ff) st_in = dnd_pkg::ST_FAIL;
         dnd_pkg::ST_COPY:
            if (rem_ff == 8'd1) st_in = dnd_pkg::ST_HEAD;
         dnd_pkg::ST_EMIT:
            if (out_free && rem_n <= NW'(8) && NW'(wc_ff) == rem_n && rem_n != '0)
               st_in = dnd_pkg::ST_CLEAR;
         dnd_pkg::ST_FAIL:
            if (out_free) st_in = dnd_pkg::ST_CLEAR;
         dnd_pkg::ST_CLEAR: st_in = dnd_pkg::ST_IDLE;
         default: st_in = dnd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pos_in = pos_ff; aft_in = aft_ff; jmp_in = jmp_ff; jn_in = jn_ff;
      ci_in = ci_ff; nl_in = nl_ff; rp_in = rp_ff; lab_in = lab_ff;
      rem_in = rem_ff; tgt_in = tgt_ff; wrd_in = wrd_ff; wc_in = wc_ff;
      ov_in = ov_ff && rsp_stall; ow_in = ow_ff; ob_in = ob_ff;
      ol_in = ol_ff; os_in = os_ff; on_in = on_ff;
      nb_we = 1'b0; nb_wa = nl_ff[NI-1:0]; nb_wd = rdata_ff;
      cmd_take = 1'b0; jclr = 1'b0;
      unique case (st_ff)
         dnd_pkg::ST_IDLE:
            if (cmd_valid) begin
               pos_in = {1'b0, cmd.start}; aft_in = {1'b0, cmd.start};
               jmp_in = 1'b0; jn_in = '0; nl_in = '0; rp_in = '0;
            end
         dnd_pkg::ST_HEAD: begin
            lab_in = rdata_ff;
            if ((rdata_ff & dnd_pkg::PTR_MASK) == dnd_pkg::PTR_MASK) begin
               pos_in = pos_ff + 10'd1;
            end else if ((rdata_ff & dnd_pkg::PTR_MASK) == 8'd0) begin
               pos_in = pos_ff + 10'd1;
               if (rdata_ff == 8'd0) begin
                  nb_we = nl_ff < NW'(NAME_CAPACITY);
                  nl_in = nl_ff + NW'(1);
                  if (!jmp_ff) aft_in = pos_ff + 10'd1;
                  wrd_in = '0; wc_in = '0;
               end else if (st_in == dnd_pkg::ST_COPY) begin
                  nb_we = 1'b1; nl_in = nl_ff + NW'(1); rem_in = rdata_ff;
               end
            end
         end
         dnd_pkg::ST_PTR2: begin
            tgt_in = {lab_ff[5:0] & dnd_pkg::OFS_MASK[5:0], rdata_ff};
            ci_in = '0;
         end
         dnd_pkg::ST_CHECK:
            if (ci_ff == jn_ff) begin
               if (!jmp_ff) aft_in = pos_ff + 10'd1;
               jmp_in = 1'b1; jn_in = jn_ff + JW'(1);
               pos_in = tgt_ff[9:0];
            end else ci_in = ci_ff + JW'(1);
         dnd_pkg::ST_COPY: begin
            nb_we = 1'b1; nl_in = nl_ff + NW'(1);
            rem_in = rem_ff - 8'd1; pos_in = pos_ff + 10'd1;
         end
         dnd_pkg::ST_EMIT: begin
            // gather bytes one per cycle, then hand the word over
            if (wc_ff != 4'd8 && rem_n != '0 && NW'(wc_ff) < rem_n) begin
               wrd_in = wrd_ff | (64'(nbrd_ff) << (6'd56 - {wc_ff[2:0], 3'b000}));
               wc_in = wc_ff + 4'd1;
            end else if (out_free) begin
               ov_in = 1'b1; ow_in = wrd_ff; ob_in = wc_ff; os_in = 1'b0;
               ol_in = (rem_n <= NW'(8)); on_in = aft_ff;
               rp_in = rp_ff + NW'(wc_ff); wrd_in = '0; wc_in = '0;
               if (rem_n <= NW'(8)) cmd_take = 1'b1;
            end
         end
         dnd_pkg::ST_FAIL:
            if (out_free) begin
               ov_in = 1'b1; ow_in = '0; ob_in = '0; ol_in = 1'b1;
               os_in = 1'b1; on_in = '0; cmd_take = 1'b1;
            end
         dnd_pkg::ST_CLEAR: jclr = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= dnd_pkg::ST_IDLE; ov_ff <= 1'b0; jn_ff <= '0;
         for (int i = 0; i < MAX_JUMPS; i++) jt_ff[i] <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; jn_ff <= jn_in;
         if (jclr) for (int i = 0; i < MAX_JUMPS; i++) jt_ff[i] <= '0;
         else if (st_ff == dnd_pkg::ST_CHECK && ci_ff == jn_ff)
            jt_ff[jn_ff[JI-1:0]] <= tgt_ff;
      end
      if (st_ff == dnd_pkg::ST_IDLE && cmd_valid) len_ff <= cmd.len;
      pos_ff <= pos_in; aft_ff <= aft_in; jmp_ff <= jmp_in; ci_ff <= ci_in;
      nl_ff <= nl_in; rp_ff <= rp_in; lab_ff <= lab_in; rem_ff <= rem_in;
      tgt_ff <= tgt_in; wrd_ff <= wrd_in; wc_ff <= wc_in;
      ow_ff <= ow_in; ob_ff <= ob_in; ol_ff <= ol_in; os_ff <= os_in;
      on_ff <= on_in;
   end
endmodule

/* design/dns_name_decompressor.sv */
`timescale 1ns / 1ps
// Byte writes are accepted back to back when no decode waits.
// A decode takes a start step, a step per label head and per label byte, and per pointer
// a head read, a second-byte read and a serial scan of the targets visited so far; then
// the end label, then per output word one buffer read per byte and one hand-over, which
// waits while rsp_stall holds. A clear state closes every decode; decodes run serially.
// Reset empties the command queue and clears the walker state and jump table.
// ----------------------------------------------------------------------------
// dns_name_decompressor
// Top level: request front end, command queue and label walker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dns_name_decompressor #(
   parameter int NAME_CAPACITY = dnd_pkg::NAME_CAPACITY_DEF,
   parameter int MAX_JUMPS     = dnd_pkg::MAX_JUMPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [8:0]  req_offset,
   input  logic [7:0]  req_byte_value,
   input  logic [9:0]  req_message_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_name_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_last_word,
   output logic        rsp_status,
   output logic [9:0]  rsp_next_offset
);
   logic             wr_en, cmd_valid, cmd_take;
   logic [8:0]       wr_addr;
   logic [7:0]       wr_data;
   dnd_pkg::cmd_type cmd;
   logic             err_shape, ok_shape;

   dnd_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_offset,
      .req_byte_value, .req_message_length, .wr_en, .wr_addr, .wr_data,
      .cmd_valid, .cmd, .cmd_take);

   dnd_back #(.NAME_CAPACITY(NAME_CAPACITY), .MAX_JUMPS(MAX_JUMPS)) u_back (
      .clock, .reset, .wr_en, .wr_addr, .wr_data, .cmd_valid, .cmd, .cmd_take,
      .rsp_valid, .rsp_stall, .rsp_name_word, .rsp_valid_bytes, .rsp_last_word,
      .rsp_status, .rsp_next_offset);

   assign err_shape = rsp_last_word && rsp_valid_bytes == 4'd0;
   assign ok_shape  = rsp_valid_bytes != 4'd0 && rsp_valid_bytes <= 4'd8;

   `CHK_IMPLY(a_err_shape, clock, reset, rsp_valid && rsp_status, err_shape)
   `CHK_IMPLY(a_ok_bytes, clock, reset, rsp_valid && !rsp_status, ok_shape)
   `CHK_IMPLY(a_take_valid, clock, reset, cmd_take, cmd_valid)
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_name_word))
endmodule
